// File: src/sfl_pkg.sv
package sfl_pkg;

    localparam int ADDR_W         = 24;
    localparam int LIMIT_W        = 25;
    localparam int PAGE_BYTES_DEF = 256;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'h0200000;

    localparam logic [1:0] LIMIT_ADDR = 2'd0;

    localparam logic [1:0] FUNC_APPEND = 2'd0;
    localparam logic [1:0] FUNC_FLUSH  = 2'd1;
    localparam logic [1:0] FUNC_STATUS = 2'd2;

    localparam logic [1:0] OUTC_OK    = 2'd0;
    localparam logic [1:0] OUTC_FULL  = 2'd1;
    localparam logic [1:0] OUTC_BUSY  = 2'd2;
    localparam logic [1:0] OUTC_UNEXP = 2'd3;

    localparam logic [7:0] OP_WREN   = 8'h06;
    localparam logic [7:0] OP_PP     = 8'h02;
    localparam logic [7:0] OP_RDSR   = 8'h05;
    localparam logic [7:0] POLL_BYTE = 8'hA5;

    // Steps of a flash command sequence, in the order the back end walks them.
    typedef enum logic [3:0] {
        STEP_WREN,
        STEP_PP,
        STEP_A2,
        STEP_A1,
        STEP_A0,
        STEP_LO,
        STEP_HI,
        STEP_REL,
        STEP_RDSR,
        STEP_DUMMY,
        STEP_NONE
    } t_step;

    typedef struct packed {
        t_step              first_step;
        t_step              last_step;
        logic [1:0]         outcome;
        logic [15:0]        halfword;
        logic [ADDR_W-1:0]  addr;
    } t_job;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] halfword;
        logic [7:0]  status_byte;
    } t_in;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] spi_out;
        logic       release_select;
        logic       status_expected;
        logic [1:0] outcome;
        logic       last;
    } t_out;

endpackage

// File: src/sfl_front.sv
module sfl_front #(
    parameter int PAGE_BYTES = sfl_pkg::PAGE_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  sfl_pkg::t_in                 i_in,
    input  logic [sfl_pkg::LIMIT_W-1:0]  i_limit,
    input  logic                         i_q_full,
    output logic                         o_in_stall,
    output logic                         o_push,
    output sfl_pkg::t_job                o_job
);

    localparam int OFF_W = $clog2(PAGE_BYTES + 2);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_OPEN,
        PH_WAIT
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic [sfl_pkg::ADDR_W-1:0]   r_log_addr;
    logic [OFF_W-1:0]             r_off, n_off, w_off_p2;
    logic                         w_boundary, w_full, w_adv;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // The page offset is tracked alongside the address so that the boundary
    // test needs no modulo; the address wrap to zero also lands on offset zero.
    always_comb begin
        w_off_p2 = r_off + OFF_W'(2);
        if (r_log_addr == {{(sfl_pkg::ADDR_W-1){1'b1}}, 1'b0}) begin
            n_off = '0;
        end else if (w_off_p2 >= OFF_W'(PAGE_BYTES)) begin
            n_off = w_off_p2 - OFF_W'(PAGE_BYTES);
        end else begin
            n_off = w_off_p2;
        end
        w_boundary = (n_off == '0);
        w_full = ({1'b0, r_log_addr} + sfl_pkg::LIMIT_W'(PAGE_BYTES)) >= i_limit;
    end

    always_comb begin
        o_job.first_step = sfl_pkg::STEP_NONE;
        o_job.last_step  = sfl_pkg::STEP_NONE;
        o_job.outcome    = sfl_pkg::OUTC_OK;
        o_job.halfword   = i_in.halfword;
        o_job.addr       = r_log_addr;
        n_phase          = r_phase;
        w_adv            = 1'b0;
        case (i_in.func)
            sfl_pkg::FUNC_APPEND: begin
                if (r_phase == PH_WAIT) begin
                    o_job.outcome = sfl_pkg::OUTC_BUSY;
                end else if (r_phase == PH_OPEN || !w_full) begin
                    o_job.first_step = (r_phase == PH_OPEN) ? sfl_pkg::STEP_LO
                                                            : sfl_pkg::STEP_WREN;
                    o_job.last_step  = w_boundary ? sfl_pkg::STEP_DUMMY
                                                  : sfl_pkg::STEP_HI;
                    n_phase          = w_boundary ? PH_WAIT : PH_OPEN;
                    w_adv            = 1'b1;
                end else begin
                    o_job.outcome = sfl_pkg::OUTC_FULL;
                end
            end
            sfl_pkg::FUNC_FLUSH: begin
                if (r_phase == PH_WAIT) begin
                    o_job.outcome = sfl_pkg::OUTC_BUSY;
                end else if (r_phase == PH_OPEN) begin
                    o_job.first_step = sfl_pkg::STEP_REL;
                    o_job.last_step  = sfl_pkg::STEP_DUMMY;
                    n_phase          = PH_WAIT;
                end
            end
            sfl_pkg::FUNC_STATUS: begin
                if (r_phase != PH_WAIT) begin
                    o_job.outcome = sfl_pkg::OUTC_UNEXP;
                end else if (i_in.status_byte[0]) begin
                    o_job.first_step = sfl_pkg::STEP_DUMMY;
                    o_job.last_step  = sfl_pkg::STEP_DUMMY;
                end else begin
                    o_job.first_step = sfl_pkg::STEP_REL;
                    o_job.last_step  = sfl_pkg::STEP_REL;
                    n_phase          = PH_IDLE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_log_addr <= '0;
            r_off      <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
            if (w_adv) begin
                r_log_addr <= r_log_addr + sfl_pkg::ADDR_W'(2);
                r_off      <= n_off;
            end
        end
    end

endmodule

// File: src/sfl_queue.sv
module sfl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sfl_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output sfl_pkg::t_job o_job
);

    localparam int DEPTH = sfl_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfl_pkg::t_job      r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr, r_rptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: src/sfl_back.sv
module sfl_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  sfl_pkg::t_job i_q_job,
    input  logic          i_out_stall,
    output logic          o_pop,
    output logic          o_out_valid,
    output sfl_pkg::t_out o_out
);

    logic            r_active;
    sfl_pkg::t_job   r_job;
    sfl_pkg::t_step  r_step, w_next_step;
    logic            r_out_valid;
    sfl_pkg::t_out   r_out, w_res;
    logic            w_can_load, w_emit, w_is_last;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_can_load = !r_out_valid || !i_out_stall;
    assign w_emit     = r_active && w_can_load;
    assign w_is_last  = (r_step == r_job.last_step);
    assign o_pop      = !i_q_empty && (!r_active || (w_emit && w_is_last));

    // After the high data byte the sequence skips the bare release step and
    // goes straight to read-status.
    always_comb begin
        if (r_step == sfl_pkg::STEP_HI) begin
            w_next_step = sfl_pkg::STEP_RDSR;
        end else begin
            w_next_step = sfl_pkg::t_step'(r_step + 4'd1);
        end
    end

    always_comb begin
        w_res.byte_valid      = 1'b1;
        w_res.spi_out         = 8'h00;
        w_res.release_select  = 1'b0;
        w_res.status_expected = 1'b0;
        w_res.outcome         = r_job.outcome;
        w_res.last            = w_is_last;
        case (r_step)
            sfl_pkg::STEP_WREN: begin
                w_res.spi_out        = sfl_pkg::OP_WREN;
                w_res.release_select = 1'b1;
            end
            sfl_pkg::STEP_PP:    w_res.spi_out = sfl_pkg::OP_PP;
            sfl_pkg::STEP_A2:    w_res.spi_out = r_job.addr[23:16];
            sfl_pkg::STEP_A1:    w_res.spi_out = r_job.addr[15:8];
            sfl_pkg::STEP_A0:    w_res.spi_out = r_job.addr[7:0];
            sfl_pkg::STEP_LO:    w_res.spi_out = r_job.halfword[7:0];
            sfl_pkg::STEP_HI: begin
                w_res.spi_out        = r_job.halfword[15:8];
                w_res.release_select = (r_job.last_step == sfl_pkg::STEP_DUMMY);
            end
            sfl_pkg::STEP_REL: begin
                w_res.byte_valid     = 1'b0;
                w_res.release_select = 1'b1;
            end
            sfl_pkg::STEP_RDSR:  w_res.spi_out = sfl_pkg::OP_RDSR;
            sfl_pkg::STEP_DUMMY: begin
                w_res.spi_out         = sfl_pkg::POLL_BYTE;
                w_res.status_expected = 1'b1;
            end
            default: begin
                w_res.byte_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_out       <= w_res;
            end else if (w_can_load) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_active <= 1'b1;
                r_job    <= i_q_job;
                r_step   <= i_q_job.first_step;
            end else if (w_emit) begin
                if (w_is_last) begin
                    r_active <= 1'b0;
                end else begin
                    r_step <= w_next_step;
                end
            end
        end
    end

endmodule

// File: src/spi_flash_log_writer_unit.sv
// Serial NOR flash log writer. Each input transfer (append, flush or status
// reply) is classified at once by the front end, which owns the log address
// and burst phase, and is queued in a two-entry queue as a command sequence.
// The back end turns each queued sequence into 1 to 9 result transfers, one
// per clock: 9 for an append that opens a burst and closes it at a page end,
// 7 for an append that opens a burst, 2 or 4 for an append into an open
// burst, 3 for a flush of an open burst, and 1 otherwise. The input side
// takes one transfer per clock while the queue has room, so throughput is
// set by the back end's one result per clock and by output stalls.
// address_limit is written through the APB port at byte address 0 and should
// only be changed while the block is idle.
module spi_flash_log_writer_unit #(
    parameter int PAGE_BYTES = sfl_pkg::PAGE_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sfl_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sfl_pkg::t_out o_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [sfl_pkg::LIMIT_W-1:0] r_limit;
    logic                        w_push, w_pop, w_q_full, w_q_empty;
    sfl_pkg::t_job               w_job_in, w_job_out;

    assign pready = 1'b1;
    assign prdata = {{(32 - sfl_pkg::LIMIT_W){1'b0}}, r_limit};

    // The only register, address_limit, sits at byte address 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= sfl_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && paddr == sfl_pkg::LIMIT_ADDR) begin
            r_limit <= pwdata[sfl_pkg::LIMIT_W-1:0];
        end
    end

    sfl_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_limit    (r_limit),
        .i_q_full   (w_q_full),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    sfl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_job   (w_job_out)
    );

    sfl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_job     (w_job_out),
        .i_out_stall (i_out_stall),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    a_status_dummy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status_expected |->
            o_out.byte_valid && o_out.spi_out == sfl_pkg::POLL_BYTE)
        else $error("status reply requested on a byte other than the dummy");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.outcome != sfl_pkg::OUTC_OK |->
            o_out.last && !o_out.byte_valid)
        else $error("refused item produced more than one result or a byte");

    a_empty_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.byte_valid |-> o_out.spi_out == 8'h00)
        else $error("result without a byte carries nonzero data");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full || w_pop)
        else $error("command queue overflow");

endmodule

// File: dv/tb_spi_flash_log_writer_unit.sv
module tb_spi_flash_log_writer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sfl_pkg::*;

    localparam int         CYCLE_LIMIT  = 500000;
    localparam int         SETTLE_TICKS = 16;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam logic [7:0] WIP_MASK     = 8'h01;
    localparam logic [24:0] LIMIT_MAX   = 25'h1000000;

    typedef enum logic [1:0] {
        LOG_IDLE,
        LOG_BURST,
        LOG_POLL
    } t_log_phase;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in         i_in        = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [1:0]  paddr       = LIMIT_ADDR;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state, mirroring the flash log as seen by the block.
    logic [23:0] log_m   = '0;
    t_log_phase  phase_m = LOG_IDLE;
    logic [24:0] limit_m = LIMIT_RESET;

    t_out spi_expect_q[$];
    t_out item_results[$];

    int fail_cnt     = 0;
    int cycle_cnt    = 0;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;

    spi_flash_log_writer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_in log_item(logic [1:0] f, logic [15:0] hw, logic [7:0] sb);
        t_in it;
        it.func        = f;
        it.halfword    = hw;
        it.status_byte = sb;
        return it;
    endfunction

    function automatic void add_result(logic v, logic [7:0] b, logic rel, logic stat);
        t_out r;
        r                 = '0;
        r.byte_valid      = v;
        r.spi_out         = v ? b : 8'h00;
        r.release_select  = rel;
        r.status_expected = stat;
        item_results.push_back(r);
    endfunction

    function automatic void start_status_poll();
        add_result(1'b1, OP_RDSR, 1'b0, 1'b0);
        add_result(1'b1, POLL_BYTE, 1'b0, 1'b1);
        phase_m = LOG_POLL;
    endfunction

    function automatic void append_halfword(logic [15:0] hw);
        logic at_page_end;
        log_m       = log_m + 24'd2;
        at_page_end = (log_m % PAGE_BYTES_DEF) == 0;
        add_result(1'b1, hw[7:0], 1'b0, 1'b0);
        add_result(1'b1, hw[15:8], at_page_end, 1'b0);
        if (at_page_end) begin
            start_status_poll();
        end
    endfunction

    function automatic void predict_spi_stream(t_in it);
        logic [1:0] outc;
        outc = OUTC_OK;
        item_results.delete();
        case (it.func)
            FUNC_APPEND: begin
                if (phase_m == LOG_POLL) begin
                    add_result(1'b0, 8'h00, 1'b0, 1'b0);
                    outc = OUTC_BUSY;
                end else if (phase_m == LOG_BURST) begin
                    append_halfword(it.halfword);
                end else if (int'(log_m) + PAGE_BYTES_DEF >= int'(limit_m)) begin
                    add_result(1'b0, 8'h00, 1'b0, 1'b0);
                    outc = OUTC_FULL;
                end else begin
                    // Write-enable is a frame of its own, then the program header.
                    add_result(1'b1, OP_WREN, 1'b1, 1'b0);
                    add_result(1'b1, OP_PP, 1'b0, 1'b0);
                    add_result(1'b1, log_m[23:16], 1'b0, 1'b0);
                    add_result(1'b1, log_m[15:8], 1'b0, 1'b0);
                    add_result(1'b1, log_m[7:0], 1'b0, 1'b0);
                    phase_m = LOG_BURST;
                    append_halfword(it.halfword);
                end
            end
            FUNC_FLUSH: begin
                if (phase_m == LOG_POLL) begin
                    add_result(1'b0, 8'h00, 1'b0, 1'b0);
                    outc = OUTC_BUSY;
                end else if (phase_m == LOG_BURST) begin
                    add_result(1'b0, 8'h00, 1'b1, 1'b0);
                    start_status_poll();
                end else begin
                    add_result(1'b0, 8'h00, 1'b0, 1'b0);
                end
            end
            FUNC_STATUS: begin
                if (phase_m != LOG_POLL) begin
                    add_result(1'b0, 8'h00, 1'b0, 1'b0);
                    outc = OUTC_UNEXP;
                end else if ((it.status_byte & WIP_MASK) != 0) begin
                    add_result(1'b1, POLL_BYTE, 1'b0, 1'b1);
                end else begin
                    add_result(1'b0, 8'h00, 1'b1, 1'b0);
                    phase_m = LOG_IDLE;
                end
            end
            default: begin
                add_result(1'b0, 8'h00, 1'b0, 1'b0);
            end
        endcase
        foreach (item_results[k]) begin
            item_results[k].outcome = outc;
        end
        item_results[item_results.size()-1].last = 1'b1;
        foreach (item_results[k]) begin
            spi_expect_q.push_back(item_results[k]);
        end
    endfunction

    task automatic check_spi_result(t_out got);
        t_out want;
        if (spi_expect_q.size() == 0) begin
            $error("unexpected result transfer: %p", got);
            fail_cnt++;
            return;
        end
        want = spi_expect_q.pop_front();
        if (got.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0d, got %0d", want.byte_valid, got.byte_valid);
            fail_cnt++;
        end
        if (got.spi_out !== want.spi_out) begin
            $error("spi_out: expected %02h, got %02h", want.spi_out, got.spi_out);
            fail_cnt++;
        end
        if (got.release_select !== want.release_select) begin
            $error("release_select: expected %0d, got %0d",
                   want.release_select, got.release_select);
            fail_cnt++;
        end
        if (got.status_expected !== want.status_expected) begin
            $error("status_expected: expected %0d, got %0d",
                   want.status_expected, got.status_expected);
            fail_cnt++;
        end
        if (got.outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
            fail_cnt++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                check_spi_result(o_out);
            end
            i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_spi_flash_log_writer_unit: FAIL");
            $finish;
        end
    end

    // Called at a clock edge; returns at the edge where the transfer is taken.
    // Valid is left high so that a following item can go out back to back.
    task automatic send_log_item(t_in it);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        predict_spi_stream(it);
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_log_drained();
        i_in_valid <= 1'b0;
        while (spi_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [24:0] v);
        wait_log_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        limit_m = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(v)) begin
            $error("address_limit: expected %0h, got %0h", v, prdata);
            fail_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_stray_items();
        send_log_item(log_item(FUNC_STATUS, 16'h0000, 8'h00));
        send_log_item(log_item(FUNC_FLUSH, 16'hFFFF, 8'hFF));
        send_log_item(log_item(FUNC_UNUSED, 16'hFFFF, 8'hFF));
    endtask

    task automatic test_burst_and_poll();
        send_log_item(log_item(FUNC_APPEND, 16'h0000, 8'hFF));
        send_log_item(log_item(FUNC_APPEND, 16'hFFFF, 8'h00));
        send_log_item(log_item(FUNC_APPEND, 16'h5AA5, 8'h00));
        send_log_item(log_item(FUNC_FLUSH, 16'h0000, 8'h00));
        // While the status poll runs, appends and flushes bounce as busy.
        send_log_item(log_item(FUNC_APPEND, 16'h1234, 8'h00));
        send_log_item(log_item(FUNC_FLUSH, 16'h0000, 8'h00));
        send_log_item(log_item(FUNC_UNUSED, 16'h0000, 8'h00));
        send_log_item(log_item(FUNC_STATUS, 16'h0000, 8'hFF));
        send_log_item(log_item(FUNC_STATUS, 16'hFFFF, 8'h01));
        send_log_item(log_item(FUNC_STATUS, 16'h0000, 8'hFE));
        send_log_item(log_item(FUNC_STATUS, 16'h0000, 8'h00));
    endtask

    task automatic test_limit_extremes();
        write_limit('0);
        send_log_item(log_item(FUNC_APPEND, 16'hFFFF, 8'h00));
        send_log_item(log_item(FUNC_FLUSH, 16'h0000, 8'h00));
        write_limit(LIMIT_MAX);
        send_log_item(log_item(FUNC_APPEND, 16'hBEEF, 8'h00));
        send_log_item(log_item(FUNC_FLUSH, 16'h0000, 8'h00));
        send_log_item(log_item(FUNC_STATUS, 16'h0000, 8'h00));
    endtask

    task automatic test_mixed_traffic(int n_items);
        int  pick;
        t_in it;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            case (phase_m)
                LOG_IDLE: begin
                    if (pick < 75) begin
                        it = log_item(FUNC_APPEND, 16'($urandom), 8'($urandom));
                    end else if (pick < 85) begin
                        it = log_item(FUNC_FLUSH, 16'($urandom), 8'($urandom));
                    end else begin
                        it = log_item(2'($urandom_range(FUNC_STATUS, FUNC_UNUSED)),
                                      16'($urandom), 8'($urandom));
                    end
                end
                LOG_BURST: begin
                    if (pick < 88) begin
                        it = log_item(FUNC_APPEND, 16'($urandom), 8'($urandom));
                    end else if (pick < 95) begin
                        it = log_item(FUNC_FLUSH, 16'($urandom), 8'($urandom));
                    end else begin
                        it = log_item(2'($urandom_range(FUNC_STATUS, FUNC_UNUSED)),
                                      16'($urandom), 8'($urandom));
                    end
                end
                default: begin
                    if (pick < 45) begin
                        it = log_item(FUNC_STATUS, 16'($urandom), 8'($urandom) | WIP_MASK);
                    end else if (pick < 85) begin
                        it = log_item(FUNC_STATUS, 16'($urandom), 8'($urandom) & ~WIP_MASK);
                    end else begin
                        it = log_item(2'($urandom_range(FUNC_APPEND, FUNC_UNUSED)),
                                      16'($urandom), 8'($urandom));
                    end
                end
            endcase
            send_log_item(it);
        end
    endtask

    task automatic test_log_full();
        write_limit(25'(int'(log_m) + PAGE_BYTES_DEF + int'($urandom_range(1, 300))));
        test_mixed_traffic(50);
        write_limit({2'b01, 23'($urandom)});
    endtask

    // Keeps appending until the page boundary closes the burst on its own.
    task automatic test_page_close();
        if (phase_m == LOG_POLL) begin
            send_log_item(log_item(FUNC_STATUS, 16'($urandom), 8'h00));
        end
        for (int i = 0; i < 140 && phase_m != LOG_POLL; i++) begin
            send_log_item(log_item(FUNC_APPEND, 16'($urandom), 8'($urandom)));
        end
        while (phase_m == LOG_POLL) begin
            send_log_item(log_item(FUNC_STATUS, 16'($urandom), 8'($urandom)));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle_pct = 21;
        rcv_idle_pct = 87;
        test_stray_items();
        test_burst_and_poll();
        test_limit_extremes();
        test_log_full();
        test_mixed_traffic(65);

        snd_idle_pct = 87;
        rcv_idle_pct = 21;
        test_page_close();
        test_mixed_traffic(65);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_mixed_traffic(65);

        wait_log_drained();
        if (fail_cnt == 0 && spi_expect_q.size() == 0) begin
            $display("tb_spi_flash_log_writer_unit: PASS");
        end else begin
            $display("tb_spi_flash_log_writer_unit: FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
src/sfl_pkg.sv
src/sfl_front.sv
src/sfl_queue.sv
src/sfl_back.sv
src/spi_flash_log_writer_unit.sv
dv/tb_spi_flash_log_writer_unit.sv
